// File: sv/running_median_filter_core_macros.svh
// ----------------------------------------------------------------------------
// running median filter assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_FILTER_CORE_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define RMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// sizes and controller command type for the running median filter
// ----------------------------------------------------------------------------
package rmf_pkg;

	localparam int WINDOW      = 10;
	localparam int SAMPLE_BITS = 16;
	localparam int STEP_BITS   = $clog2(WINDOW);
	localparam int MEDIAN_POS  = WINDOW / 2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [STEP_BITS-1:0]   step_t;

	// commands from controller to datapath
	typedef struct packed {
		logic start;     // sample transfer, shift ring, seed the pass
		logic step;      // one position of the sorted pass
		logic last;      // final position, write the carried value
		logic load_out;  // capture the median into the output register
	} cmd_t;

endpackage

// File: sv/rmf_ctrl.sv
// ----------------------------------------------------------------------------
// rmf_ctrl
// controller: accepts a sample, sequences the pass over the sorted window,
// then hands the median to the output register
// ----------------------------------------------------------------------------
`include "running_median_filter_core_macros.svh"

module rmf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_ready,
	output logic          median_valid,
	input  logic          median_ready,
	output rmf_pkg::cmd_t cmd
);
	import rmf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

	state_t state_q;
	step_t  cnt_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || median_ready;
	assign sample_ready = (state_q == ST_IDLE);
	assign median_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd.start    = (state_q == ST_IDLE) && sample_valid;
		cmd.step     = (state_q == ST_RUN);
		cmd.last     = (state_q == ST_RUN) && (cnt_q == STEP_BITS'(WINDOW - 1));
		cmd.load_out = (state_q == ST_WAIT) && out_free;
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (median_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (sample_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + step_t'(1);
					if (cmd.last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`RMF_ASSERT_NEXT(a_start_runs, cmd.start, state_q == ST_RUN && cnt_q == '0,
		"pass did not begin after sample transfer")
	`RMF_ASSERT_NEXT(a_last_waits, cmd.last, state_q == ST_WAIT,
		"pass did not end after last position")
	`RMF_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_q || median_ready,
		"median loaded over an untaken result")
	`RMF_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid_q,
		"loaded median not presented")

endmodule

// File: sv/rmf_datapath.sv
// ----------------------------------------------------------------------------
// rmf_datapath
// arrival shift line and rotating sorted window; one sorted position per
// step, the window rotates through a full turn during the pass
// ----------------------------------------------------------------------------
module rmf_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  rmf_pkg::cmd_t    cmd,
	input  rmf_pkg::sample_t sample,
	output rmf_pkg::sample_t median
);
	import rmf_pkg::*;

	sample_t ring_q   [WINDOW];
	sample_t sorted_q [WINDOW];
	sample_t evicted_q;
	sample_t carry_q;
	sample_t median_q;
	logic    del_q;
	logic    shf_q;

	sample_t cur;
	sample_t put;
	sample_t carry_n;
	logic    del_n;
	logic    shf_n;

	// one position of the delete and insert pass
	always_comb begin
		cur     = sorted_q[0];
		del_n   = del_q;
		shf_n   = shf_q;
		carry_n = carry_q;
		if (del_q || (sorted_q[0] == evicted_q)) begin
			cur   = sorted_q[1];
			del_n = 1'b1;
		end
		put = cur;
		if (shf_q || (carry_q < cur)) begin
			put     = carry_q;
			carry_n = cur;
			shf_n   = 1'b1;
		end
		if (cmd.last) begin
			put = carry_q;
		end
	end

	// window stores, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_q[i]   <= '0;
				sorted_q[i] <= '0;
			end
		end else begin
			if (cmd.start) begin
				for (int i = 0; i < WINDOW - 1; i++) begin
					ring_q[i] <= ring_q[i + 1];
				end
				ring_q[WINDOW - 1] <= sample;
			end
			if (cmd.step) begin
				for (int i = 0; i < WINDOW - 1; i++) begin
					sorted_q[i] <= sorted_q[i + 1];
				end
				sorted_q[WINDOW - 1] <= put;
			end
		end
	end

	// pass working registers and output register
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			evicted_q <= ring_q[0];
			carry_q   <= sample;
			del_q     <= 1'b0;
			shf_q     <= 1'b0;
		end else if (cmd.step) begin
			carry_q <= carry_n;
			del_q   <= del_n;
			shf_q   <= shf_n;
		end
		if (cmd.load_out) begin
			median_q <= sorted_q[MEDIAN_POS];
		end
	end

	assign median = median_q;

endmodule

// File: sv/running_median_filter_core.sv
// ----------------------------------------------------------------------------
// running_median_filter_core
// sliding-window median of echo pulse widths over the last ten samples
// ----------------------------------------------------------------------------
// usage:
//   input channel sample / sample_valid / sample_ready, one 16-bit unsigned
//   pulse width per transfer; output channel median / median_valid /
//   median_ready, one upper median (sorted index WINDOW/2) per sample.
//   a sample transfer shifts it into the arrival line and starts a pass that
//   walks the sorted window one position per cycle, removing the evicted
//   value and inserting the new one. a new sample is taken only when idle,
//   after the previous pass has loaded its median into the output register.
//   the median sits in an output register; a stalled receiver holds it, and
//   the block finishes the next pass and waits for the register to free.
//   reset clears both window stores to zero, so the first medians include
//   those zeros until the window has filled.
// ----------------------------------------------------------------------------
module running_median_filter_core (
	input  logic             clk,
	input  logic             arst_n,
	input  rmf_pkg::sample_t sample,
	input  logic             sample_valid,
	output logic             sample_ready,
	output rmf_pkg::sample_t median,
	output logic             median_valid,
	input  logic             median_ready
);
	import rmf_pkg::*;

	cmd_t cmd;

	// sequencing
	rmf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.median_valid (median_valid),
		.median_ready (median_ready),
		.cmd          (cmd)
	);

	// window storage and pass logic
	rmf_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.median (median)
	);

endmodule
